/* rtl/lbrb_pkg.sv */
// Shared types and constants for the log block retransmit buffer.
// Used by lbrb_ctrl, lbrb_dpath and log_block_retransmit_buffer; no dependencies.
package lbrb_pkg;

	localparam int SEQ_W     = 32;
	localparam int ACT_W     = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 9;

	// action codes
	localparam logic [ACT_W-1:0] ACT_WRITE = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ACK   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_RETRY = 3'd2;
	localparam logic [ACT_W-1:0] ACT_START = 3'd3;
	localparam logic [ACT_W-1:0] ACT_STOP  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_READ  = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WRITES_ENABLED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE   = 2'd2;

	// reset values of the configuration registers
	localparam logic       RST_WRITES_ENABLED = 1'b1;
	localparam logic [8:0] RST_BLOCK_SIZE     = 9'd200;
	localparam logic [3:0] RST_SLOTS_IN_USE   = 4'd8;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [7:0]       data_byte;
		logic [SEQ_W-1:0] block_number;
		logic [2:0]       read_slot;
		logic [7:0]       read_offset;
		logic             link_ready;
	} in_item_t;

	typedef struct packed {
		logic             send_valid;
		logic [2:0]       send_slot;
		logic [SEQ_W-1:0] send_sequence;
		logic             overrun;
		logic [7:0]       read_data;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_READ,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic wr_byte;
		logic scan_start;
		logic scan_step;
		logic do_start;
		logic do_stop;
		logic rd_issue;
		logic rd_capture;
		logic emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             seal;
		logic             scan_end;
		logic             out_free;
	} ctrl_status_t;

endpackage

/* rtl/lbrb_ram.sv */
// Generic single write port RAM with registered read.
// No dependencies.
module lbrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/lbrb_ctrl.sv */
// Sequencing state machine: accepts one item, steps the datapath through it, emits the result.
// Depends on lbrb_pkg.
module lbrb_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  lbrb_pkg::ctrl_status_t  status,
	output lbrb_pkg::ctrl_cmd_t     cmd
);

	lbrb_pkg::state_t state_q;
	lbrb_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbrb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lbrb_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = lbrb_pkg::ST_EXEC;
				end
			end
			lbrb_pkg::ST_EXEC: begin
				unique case (status.action)
					lbrb_pkg::ACT_WRITE: begin
						state_d = status.seal ? lbrb_pkg::ST_SCAN : lbrb_pkg::ST_DONE;
					end
					lbrb_pkg::ACT_ACK,
					lbrb_pkg::ACT_RETRY: state_d = lbrb_pkg::ST_SCAN;
					lbrb_pkg::ACT_READ:  state_d = lbrb_pkg::ST_READ;
					default:             state_d = lbrb_pkg::ST_DONE;
				endcase
			end
			lbrb_pkg::ST_SCAN: begin
				if (status.scan_end) begin
					state_d = lbrb_pkg::ST_DONE;
				end
			end
			lbrb_pkg::ST_READ: state_d = lbrb_pkg::ST_DONE;
			lbrb_pkg::ST_DONE: begin
				if (status.out_free) begin
					state_d = lbrb_pkg::ST_IDLE;
				end
			end
			default: state_d = lbrb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			lbrb_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			lbrb_pkg::ST_EXEC: begin
				unique case (status.action)
					lbrb_pkg::ACT_WRITE: begin
						cmd.wr_byte    = 1'b1;
						cmd.scan_start = status.seal;
					end
					lbrb_pkg::ACT_ACK,
					lbrb_pkg::ACT_RETRY: cmd.scan_start = 1'b1;
					lbrb_pkg::ACT_START: cmd.do_start   = 1'b1;
					lbrb_pkg::ACT_STOP:  cmd.do_stop    = 1'b1;
					lbrb_pkg::ACT_READ:  cmd.rd_issue   = 1'b1;
					default: ;
				endcase
			end
			lbrb_pkg::ST_SCAN: cmd.scan_step  = 1'b1;
			lbrb_pkg::ST_READ: cmd.rd_capture = 1'b1;
			lbrb_pkg::ST_DONE: cmd.emit       = status.out_free;
			default: ;
		endcase
	end

endmodule

/* rtl/lbrb_dpath.sv */
// Datapath: configuration, slot sequence table, fill state, slot scan, byte store, result register.
// Depends on lbrb_pkg and lbrb_ram.
module lbrb_dpath #(
	parameter int NUM_SLOTS   = 8,
	parameter int BLOCK_BYTES = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [lbrb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lbrb_pkg::CFG_DAT_W-1:0]      cfg_data,
	input  lbrb_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output lbrb_pkg::out_item_t                 out_data,
	input  lbrb_pkg::ctrl_cmd_t                 cmd,
	output lbrb_pkg::ctrl_status_t              status
);

	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int OFF_W     = $clog2(BLOCK_BYTES);
	// slots_in_use is four bits wide, so no more than fifteen slots are ever touched
	localparam int TBL_N     = (NUM_SLOTS < 15) ? NUM_SLOTS : 15;
	localparam int TI_W      = $clog2(TBL_N);
	localparam int CNT_W     = OFF_W + 1;
	localparam int CMP_W     = (CNT_W > 9) ? CNT_W : 9;
	localparam int RS_W      = (SLOT_W > 3) ? SLOT_W : 3;
	localparam int RO_W      = (OFF_W > 8) ? OFF_W : 8;
	localparam int RAM_DEPTH = NUM_SLOTS * (1 << OFF_W);
	localparam int RAM_AW    = SLOT_W + OFF_W;

	// configuration
	logic       wen_q;
	logic [8:0] bsize_q;
	logic [3:0] slots_q;

	// control state
	logic                       session_q;
	logic [TI_W-1:0]            cur_q;
	logic [OFF_W-1:0]           fill_q;
	logic [lbrb_pkg::SEQ_W-1:0] next_seq_q;
	logic [lbrb_pkg::SEQ_W-1:0] seq_q [TBL_N];
	logic [TI_W-1:0]            scan_idx_q;
	logic                       out_valid_q;

	// payload
	lbrb_pkg::in_item_t         item_q;
	lbrb_pkg::out_item_t        res_q;
	lbrb_pkg::out_item_t        out_q;
	logic [TI_W-1:0]            best_idx_q;
	logic [lbrb_pkg::SEQ_W-1:0] best_val_q;

	logic [CMP_W-1:0]           bs_ext;
	logic [CMP_W-1:0]           eff_bs;
	logic [CNT_W-1:0]           fill_next;
	logic                       write_ok;
	logic                       seal;
	logic [3:0]                 last4;
	logic [TI_W-1:0]            eff_last;
	logic [lbrb_pkg::SEQ_W-1:0] scan_val;
	logic                       scan_last;
	logic                       scan_hit;
	logic                       is_find;
	logic                       scan_end;
	logic                       take_min;
	logic [TI_W-1:0]            min_idx;
	logic [lbrb_pkg::SEQ_W-1:0] min_val;
	logic                       rd_ok;
	logic [RS_W-1:0]            rd_slot_ext;
	logic [RO_W-1:0]            rd_off_ext;
	logic [RAM_AW-1:0]          ram_waddr;
	logic [RAM_AW-1:0]          ram_raddr;
	logic [7:0]                 ram_rdata;
	logic                       ram_we;

	// effective block size: zero acts as one, capped at the slot size
	always_comb begin
		bs_ext = CMP_W'(bsize_q);
		if (bsize_q == 9'd0) begin
			eff_bs = CMP_W'(1);
		end else if (bs_ext > CMP_W'(BLOCK_BYTES)) begin
			eff_bs = CMP_W'(BLOCK_BYTES);
		end else begin
			eff_bs = bs_ext;
		end
	end

	assign fill_next = {1'b0, fill_q} + CNT_W'(1);
	assign write_ok  = session_q & wen_q;
	assign seal      = CMP_W'(fill_next) >= eff_bs;

	// index of the last slot searched
	always_comb begin
		if (slots_q == 4'd0) begin
			last4 = 4'd0;
		end else if ({3'b000, slots_q} > 7'(NUM_SLOTS)) begin
			last4 = 4'(TBL_N - 1);
		end else begin
			last4 = slots_q - 4'd1;
		end
	end

	assign eff_last = last4[TI_W-1:0];

	// one slot per cycle: track the minimum, or stop at the first match
	assign scan_val  = seq_q[scan_idx_q];
	assign scan_last = scan_idx_q == eff_last;
	assign scan_hit  = scan_val == item_q.block_number;
	assign is_find   = item_q.action != lbrb_pkg::ACT_WRITE;
	assign scan_end  = scan_last || (is_find && scan_hit);
	assign take_min  = (scan_idx_q == '0) || (scan_val < best_val_q);
	assign min_idx   = take_min ? scan_idx_q : best_idx_q;
	assign min_val   = take_min ? scan_val : best_val_q;

	// byte store addressing
	assign rd_ok       = ({4'b0000, item_q.read_slot} < 7'(NUM_SLOTS))
		&& ({3'b000, item_q.read_offset} < 11'(BLOCK_BYTES));
	assign rd_slot_ext = RS_W'(item_q.read_slot);
	assign rd_off_ext  = RO_W'(item_q.read_offset);
	assign ram_raddr   = {rd_slot_ext[SLOT_W-1:0], rd_off_ext[OFF_W-1:0]};
	assign ram_waddr   = {SLOT_W'(cur_q), fill_q};
	assign ram_we      = cmd.wr_byte & write_ok;

	lbrb_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_bytes (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (item_q.data_byte),
		.re    (cmd.rd_issue),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wen_q       <= lbrb_pkg::RST_WRITES_ENABLED;
			bsize_q     <= lbrb_pkg::RST_BLOCK_SIZE;
			slots_q     <= lbrb_pkg::RST_SLOTS_IN_USE;
			session_q   <= 1'b0;
			cur_q       <= '0;
			fill_q      <= '0;
			next_seq_q  <= '0;
			scan_idx_q  <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < TBL_N; i++) begin
				seq_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					lbrb_pkg::CFG_WRITES_ENABLED: wen_q   <= cfg_data[0];
					lbrb_pkg::CFG_BLOCK_SIZE:     bsize_q <= cfg_data;
					lbrb_pkg::CFG_SLOTS_IN_USE:   slots_q <= cfg_data[3:0];
					default: ;
				endcase
			end

			if (cmd.wr_byte && write_ok) begin
				if (seal) begin
					seq_q[cur_q] <= next_seq_q;
					next_seq_q   <= next_seq_q + lbrb_pkg::SEQ_W'(1);
					fill_q       <= '0;
				end else begin
					fill_q <= fill_next[OFF_W-1:0];
				end
			end

			if (cmd.scan_start) begin
				scan_idx_q <= '0;
			end

			if (cmd.scan_step) begin
				if (!scan_end) begin
					scan_idx_q <= scan_idx_q + TI_W'(1);
				end else if (!is_find) begin
					cur_q <= min_idx;
				end else if (item_q.action == lbrb_pkg::ACT_ACK && scan_hit) begin
					seq_q[scan_idx_q] <= '0;
				end
			end

			if (cmd.do_start && !session_q) begin
				session_q  <= 1'b1;
				next_seq_q <= '0;
				cur_q      <= '0;
				fill_q     <= '0;
				for (int i = 0; i < TBL_N; i++) begin
					seq_q[i] <= '0;
				end
			end

			if (cmd.do_stop) begin
				session_q <= 1'b0;
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
			res_q  <= '0;
		end

		if (cmd.wr_byte && write_ok && seal && item_q.link_ready) begin
			res_q.send_valid    <= 1'b1;
			res_q.send_slot     <= 3'(cur_q);
			res_q.send_sequence <= next_seq_q;
		end

		if (cmd.scan_step) begin
			best_idx_q <= min_idx;
			best_val_q <= min_val;
			if (scan_end && !is_find) begin
				res_q.overrun <= min_val != '0;
			end
			if (item_q.action == lbrb_pkg::ACT_RETRY && scan_hit && item_q.link_ready) begin
				res_q.send_valid    <= 1'b1;
				res_q.send_slot     <= 3'(scan_idx_q);
				res_q.send_sequence <= scan_val;
			end
		end

		if (cmd.rd_capture) begin
			res_q.read_data <= rd_ok ? ram_rdata : 8'd0;
		end

		if (cmd.emit) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign status.action   = item_q.action;
	assign status.seal     = write_ok & seal;
	assign status.scan_end = scan_end;
	assign status.out_free = !out_valid_q || !out_stall;

endmodule

/* rtl/log_block_retransmit_buffer.sv */
// Log block retransmit buffer: one item in, one result out, one item in flight at a time.
// Each item passes an execute and a done state; a read adds a capture state, ack and retry
// scan the slots to the first match, and a sealing write scans every slot in use.
// The slot scan visits one sequence number per cycle. An item is taken after the previous
// result is emitted; the result register lets the next item enter while a
// result waits. Reset clears the table, counters and session; the byte store is not cleared.
// Depends on lbrb_pkg, lbrb_ctrl, lbrb_dpath.
module log_block_retransmit_buffer #(
	parameter int NUM_SLOTS   = 8,
	parameter int BLOCK_BYTES = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lbrb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lbrb_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  lbrb_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output lbrb_pkg::out_item_t            out_data
);

	lbrb_pkg::ctrl_cmd_t    cmd;
	lbrb_pkg::ctrl_status_t status;

	// configuration transfers are always taken
	assign cfg_ready = 1'b1;

	lbrb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	lbrb_dpath #(
		.NUM_SLOTS   (NUM_SLOTS),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

/* tb/sv/log_block_retransmit_buffer_tb.sv */
// Testbench for log_block_retransmit_buffer: directed and random actions with a scoreboard
// that predicts each result from its own copy of the slot table and byte store.
// Depends on lbrb_pkg and the log_block_retransmit_buffer RTL.
`timescale 1ns / 1ps

module log_block_retransmit_buffer_tb;
	import lbrb_pkg::*;

	localparam int POOL_SLOTS  = 8;
	localparam int BLOCK_LEN   = 256;
	// quiet cycles allowed
	localparam int QUIET_LIMIT = 4000;
	localparam int REPORT_MAX  = 10;

	// undefined action codes, expected to be ignored
	localparam logic [ACT_W-1:0] ACT_RSVD_LO = 3'd6;
	localparam logic [ACT_W-1:0] ACT_RSVD_HI = 3'd7;

	class retransmit_scoreboard;
		logic [SEQ_W-1:0] slot_seq [POOL_SLOTS];
		logic [7:0]       slot_byte [POOL_SLOTS*BLOCK_LEN];
		bit               byte_written [POOL_SLOTS*BLOCK_LEN];
		int unsigned      written_addr [$];
		logic [2:0]       cur_slot;
		logic [8:0]       fill;
		logic [SEQ_W-1:0] next_seq;
		bit               active;
		logic             wr_en;
		logic [8:0]       blk_size;
		logic [3:0]       slot_limit;
		out_item_t        expected_outcomes [$];
		int               mismatches;

		function new();
			foreach (slot_seq[i])
				slot_seq[i] = '0;
			cur_slot   = '0;
			fill       = '0;
			next_seq   = '0;
			active     = 1'b0;
			wr_en      = RST_WRITES_ENABLED;
			blk_size   = RST_BLOCK_SIZE;
			slot_limit = RST_SLOTS_IN_USE;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			case (idx)
				CFG_WRITES_ENABLED: wr_en = val[0];
				CFG_BLOCK_SIZE:     blk_size = val;
				CFG_SLOTS_IN_USE:   slot_limit = val[3:0];
				default: ;
			endcase
		endfunction

		function int unsigned seal_threshold();
			if (blk_size == 0)
				return 1;
			if (blk_size > BLOCK_LEN)
				return BLOCK_LEN;
			return 32'(blk_size);
		endfunction

		function int unsigned slots_searched();
			if (slot_limit == 0)
				return 1;
			if (slot_limit > POOL_SLOTS)
				return POOL_SLOTS;
			return 32'(slot_limit);
		endfunction

		function int first_slot_with(logic [SEQ_W-1:0] seq);
			int i;
			for (i = 0; i < slots_searched(); i++)
				if (slot_seq[i] == seq)
					return i;
			return -1;
		endfunction

		function void note_action(in_item_t it);
			out_item_t   res;
			int unsigned addr;
			int unsigned oldest;
			int          hit;
			int          i;
			res = '0;
			case (it.action)
				ACT_WRITE: begin
					if (active && wr_en) begin
						addr = 32'({cur_slot, fill[7:0]});
						slot_byte[addr] = it.data_byte;
						if (!byte_written[addr]) begin
							byte_written[addr] = 1'b1;
							written_addr.push_back(addr);
						end
						fill = {1'b0, fill[7:0]} + 9'd1;
						if (fill >= seal_threshold()) begin
							slot_seq[cur_slot] = next_seq;
							next_seq = next_seq + 1;
							if (it.link_ready) begin
								res.send_valid    = 1'b1;
								res.send_slot     = cur_slot;
								res.send_sequence = slot_seq[cur_slot];
							end
							// lowest index wins among equal sequence numbers
							oldest = 0;
							for (i = 1; i < slots_searched(); i++)
								if (slot_seq[i] < slot_seq[oldest])
									oldest = i;
							cur_slot    = oldest[2:0];
							res.overrun = (slot_seq[cur_slot] != 0);
							fill        = '0;
						end
					end
				end
				ACT_ACK: begin
					hit = first_slot_with(it.block_number);
					if (hit >= 0)
						slot_seq[hit] = '0;
				end
				ACT_RETRY: begin
					hit = first_slot_with(it.block_number);
					if (hit >= 0 && it.link_ready) begin
						res.send_valid    = 1'b1;
						res.send_slot     = hit[2:0];
						res.send_sequence = slot_seq[hit];
					end
				end
				ACT_START: begin
					if (!active) begin
						active = 1'b1;
						foreach (slot_seq[j])
							slot_seq[j] = '0;
						next_seq = '0;
						cur_slot = '0;
						fill     = '0;
					end
				end
				ACT_STOP: active = 1'b0;
				ACT_READ: begin
					addr = 32'({it.read_slot, it.read_offset});
					res.read_data = slot_byte[addr];
				end
				default: ;
			endcase
			expected_outcomes.push_back(res);
		endfunction

		function void check_outcome(out_item_t got);
			out_item_t want;
			if (expected_outcomes.size() == 0) begin
				mismatches++;
				// fields: valid/slot/seq/overrun/read data
				if (mismatches <= REPORT_MAX)
					$display("%0t: unexpected result %0d/%0d/%h/%0d/%h",
						$realtime, got.send_valid, got.send_slot, got.send_sequence, got.overrun,
						got.read_data);
				return;
			end
			want = expected_outcomes.pop_front();
			if (got.send_valid !== want.send_valid || got.send_slot !== want.send_slot ||
			    got.send_sequence !== want.send_sequence || got.overrun !== want.overrun ||
			    got.read_data !== want.read_data) begin
				mismatches++;
				// fields: valid/slot/seq/overrun/read data
				if (mismatches <= REPORT_MAX)
					$display("%0t: mismatch exp %0d/%0d/%h/%0d/%h got %0d/%0d/%h/%0d/%h",
						$realtime, want.send_valid, want.send_slot, want.send_sequence,
						want.overrun, want.read_data, got.send_valid, got.send_slot,
						got.send_sequence, got.overrun, got.read_data);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	in_item_t             in_data;
	logic                 out_valid;
	logic                 out_stall;
	out_item_t            out_data;

	int                   in_idle_pct;
	int                   out_stall_pct;
	int                   quiet_cycles;
	retransmit_scoreboard sb;

	log_block_retransmit_buffer #(
		.NUM_SLOTS  (POOL_SLOTS),
		.BLOCK_BYTES(BLOCK_LEN)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < out_stall_pct);
	end

	// note inputs before checking outputs; a result never belongs to the item taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_action(in_data);
			if (out_valid && !out_stall)
				sb.check_outcome(out_data);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_item_t mk_item(logic [ACT_W-1:0] act, logic [7:0] data,
		logic [SEQ_W-1:0] bnum, logic [2:0] rslot, logic [7:0] roff, logic ready);
		in_item_t it;
		it.action       = act;
		it.data_byte    = data;
		it.block_number = bnum;
		it.read_slot    = rslot;
		it.read_offset  = roff;
		it.link_ready   = ready;
		return it;
	endfunction

	function automatic in_item_t random_item();
		in_item_t    it;
		int          r;
		int unsigned addr;
		it = mk_item(ACT_WRITE, 8'($urandom), $urandom, 3'($urandom), 8'($urandom),
			$urandom_range(9) != 0);
		r  = $urandom_range(99);
		if (!sb.active && r < 70)
			it.action = ACT_START;
		else if (r < 55)
			it.action = ACT_WRITE;
		else if (r < 65)
			it.action = ACT_ACK;
		else if (r < 74)
			it.action = ACT_RETRY;
		else if (r < 77)
			it.action = ACT_START;
		else if (r < 79)
			it.action = ACT_STOP;
		else if (r < 93)
			it.action = ACT_READ;
		else if (r < 96)
			it.action = $urandom_range(1) ? ACT_RSVD_HI : ACT_RSVD_LO;
		else
			it.action = ACT_W'($urandom_range(7));

		// aim most acks and retries at sequence numbers that are live
		if (it.action == ACT_ACK || it.action == ACT_RETRY) begin
			case ($urandom_range(3))
				0, 1: it.block_number = sb.slot_seq[$urandom_range(POOL_SLOTS-1)];
				2:    it.block_number = sb.next_seq - 1 - $urandom_range(2);
				default: ;
			endcase
		end

		// read only bytes that have been stored
		if (it.action == ACT_READ) begin
			if (sb.written_addr.size() == 0) begin
				it.action = ACT_ACK;
			end else begin
				addr = sb.written_addr[$urandom_range(sb.written_addr.size() - 1)];
				it.read_slot   = addr[10:8];
				it.read_offset = addr[7:0];
			end
		end
		return it;
	endfunction

	task automatic push_item(input in_item_t it);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic configure(input logic we, input logic [8:0] bs, input logic [3:0] siu);
		write_reg(CFG_WRITES_ENABLED, {8'd0, we});
		write_reg(CFG_BLOCK_SIZE, bs);
		write_reg(CFG_SLOTS_IN_USE, {5'd0, siu});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// hold input low until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input logic we, input logic [8:0] bs, input logic [3:0] siu,
		input int idle_in, input int idle_out, input int n_items, input int prefill);
		configure(we, bs, siu);
		in_idle_pct   = idle_in;
		out_stall_pct = idle_out;
		// restart the session and write a run of bytes long enough to cover every offset
		if (prefill > 0) begin
			push_item(mk_item(ACT_STOP, 8'($urandom), $urandom, 3'($urandom),
				8'($urandom), 1'b1));
			push_item(mk_item(ACT_START, 8'($urandom), $urandom, 3'($urandom),
				8'($urandom), 1'b1));
			repeat (prefill)
				push_item(mk_item(ACT_WRITE, 8'($urandom), $urandom, 3'($urandom),
					8'($urandom), $urandom_range(3) != 0));
		end
		repeat (n_items)
			push_item(random_item());
		drain();
	endtask

	initial begin
		sb            = new();
		in_idle_pct   = 0;
		out_stall_pct = 0;
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		in_data       <= '0;
		out_stall     <= 1'b0;
		quiet_cycles  <= 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: two-byte blocks over three slots
		configure(1'b1, 9'd2, 4'd3);
		push_item(mk_item(ACT_STOP,  8'h00, 32'h0, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_WRITE, 8'h11, 32'h0, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_START, 8'h00, 32'h0, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_WRITE, 8'h00, 32'h0, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_WRITE, 8'hFF, 32'h0, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_WRITE, 8'hA5, 32'h0, 3'd0, 8'h00, 1'b0));
		push_item(mk_item(ACT_WRITE, 8'h5A, 32'h0, 3'd0, 8'h00, 1'b0));
		push_item(mk_item(ACT_RETRY, 8'h00, 32'd1, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_RETRY, 8'h00, 32'd1, 3'd0, 8'h00, 1'b0));
		push_item(mk_item(ACT_RETRY, 8'h00, 32'h1234_5678, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_ACK,   8'h00, 32'hFFFF_FFFF, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_START, 8'h00, 32'h0, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_READ,  8'h00, 32'h0, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_READ,  8'h00, 32'h0, 3'd0, 8'h01, 1'b1));
		push_item(mk_item(ACT_WRITE, 8'h80, 32'h0, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_WRITE, 8'h7F, 32'h0, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_WRITE, 8'h01, 32'h0, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_WRITE, 8'hFE, 32'h0, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_ACK,   8'h00, 32'd1, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_ACK,   8'h00, 32'd0, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_RETRY, 8'h00, 32'd2, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_RSVD_LO, 8'hFF, 32'hFFFF_FFFF, 3'd7, 8'hFF, 1'b1));
		push_item(mk_item(ACT_RSVD_HI, 8'hFF, 32'hFFFF_FFFF, 3'd7, 8'hFF, 1'b1));
		push_item(mk_item(ACT_STOP,  8'h00, 32'h0, 3'd0, 8'h00, 1'b1));
		push_item(mk_item(ACT_READ,  8'h00, 32'h0, 3'd2, 8'h01, 1'b1));
		drain();

		run_phase(1'b1, 9'd1,   4'd8,  0,  0,  200, 0);
		run_phase(1'b1, 9'd4,   4'd2,  45, 0,  200, 0);
		run_phase(1'b0, 9'd3,   4'd4,  0,  45, 120, 0);
		run_phase(1'b1, 9'd0,   4'd1,  15, 15, 200, 0);
		run_phase(1'b1, 9'd256, 4'd15, 0,  0,  260, BLOCK_LEN);
		run_phase(1'b1, 9'd511, 4'd0,  45, 0,  180, 0);
		run_phase(1'b1, 9'd5,   4'd8,  0,  45, 200, 0);
		run_phase(1'b1, 9'd7,   4'd5,  15, 15, 200, 0);
		run_phase(1'b1, 9'd2,   4'd6,  0,  0,  150, 0);

		repeat (30) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_outcomes.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
